// ----- design/dvrt_pkg.sv -----
// Shared types and constants for the distance-vector route table.
package dvrt_pkg;

    localparam logic [2:0] MODE_LOCAL = 3'd0;
    localparam logic [2:0] MODE_ADV   = 3'd1;
    localparam logic [2:0] MODE_QUERY = 3'd2;
    localparam logic [2:0] MODE_DUMP  = 3'd3;
    localparam logic [2:0] MODE_TICK  = 3'd4;

    localparam logic [4:0] METRIC_INF     = 5'd16;
    localparam logic [4:0] METRIC_ADV_MAX = 5'd15;
    localparam logic [4:0] METRIC_LOCAL   = 5'd0;

    typedef struct packed {
        logic [2:0]  mode;
        logic [31:0] dest_addr;
        logic [31:0] adv_metric;
        logic [15:0] link_cost;
        logic [31:0] neighbor_addr;
        logic [3:0]  port_in;
    } in_item_t;

    typedef struct packed {
        logic [31:0] addr_out;
        logic [4:0]  metric_out;
        logic [31:0] next_hop_out;
        logic [3:0]  port_out;
        logic        found;
        logic        installed;
        logic        table_full;
        logic        last;
    } out_item_t;

    typedef struct packed {
        logic        valid;
        logic [31:0] dest;
        logic [4:0]  metric;
        logic [31:0] next_hop;
        logic [3:0]  port;
    } route_t;

    typedef struct packed {
        logic shift;
        logic wr;
    } cell_ctrl_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_COMMIT,
        ST_DUMP,
        ST_FLUSH
    } state_t;

endpackage

// ----- design/dvrt_cell.sv -----
// One route slot of the rotating table ring.
module dvrt_cell
    import dvrt_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  cell_ctrl_t ctrl,
    input  route_t     wr_route,
    input  route_t     nbr_route,
    output route_t     route
);

    logic        valid_reg;
    logic [31:0] dest_reg;
    logic [4:0]  metric_reg;
    logic [31:0] hop_reg;
    logic [3:0]  port_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (ctrl.wr) begin
            valid_reg <= 1'b1;
        end else if (ctrl.shift) begin
            valid_reg <= nbr_route.valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (ctrl.wr) begin
            dest_reg   <= wr_route.dest;
            metric_reg <= wr_route.metric;
            hop_reg    <= wr_route.next_hop;
            port_reg   <= wr_route.port;
        end else if (ctrl.shift) begin
            dest_reg   <= nbr_route.dest;
            metric_reg <= nbr_route.metric;
            hop_reg    <= nbr_route.next_hop;
            port_reg   <= nbr_route.port;
        end
    end

    assign route = '{valid: valid_reg, dest: dest_reg, metric: metric_reg,
                     next_hop: hop_reg, port: port_reg};

endmodule

// ----- design/distance_vector_route_table.sv -----
// Top level of the distance-vector route table: slot ring and sequencer.
// The table is a ring of TABLE_DEPTH slot cells that rotates one place per
// cycle, while scanning or dumping and not held by the result side, past a
// single head cell, where every lookup compare and dump read happens.
// Install, advertise and query items each go through accept, one full
// rotation and commit; commit waits while the result side holds off. A
// dump, or a tick with the changed flag set, makes one full rotation and a
// flush, held up while the result side holds off, and emits the valid
// slots in ascending slot order with last on the final one. The result
// register lets a new item be accepted while the previous result still waits.
module distance_vector_route_table
    import dvrt_pkg::*;
#(
    parameter int TABLE_DEPTH = 32,
    parameter int NUM_PORTS   = 16
) (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    output logic      s_ready,
    input  in_item_t  s_data,
    output logic      m_valid,
    input  logic      m_ready,
    output out_item_t m_data
);

    localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

    state_t            state_reg, state_next;
    in_item_t          in_reg, in_next;
    logic [IDX_W-1:0]  step_reg, step_next;
    logic              match_found_reg, match_found_next;
    logic [IDX_W-1:0]  match_idx_reg, match_idx_next;
    route_t            match_reg, match_next;
    logic              free_found_reg, free_found_next;
    logic [IDX_W-1:0]  free_idx_reg, free_idx_next;
    logic              changed_reg, changed_next;
    route_t            pend_reg, pend_next;
    logic              pend_valid_reg, pend_valid_next;
    logic              m_valid_reg, m_valid_next;
    out_item_t         m_data_reg, m_data_next;

    route_t            ring [TABLE_DEPTH];
    route_t            head;
    logic              shift_en;
    logic              wr_en;
    logic [IDX_W-1:0]  wr_idx;
    route_t            wr_route;

    // commit-time values
    logic              is_insert;
    logic              port_ok;
    logic [4:0]        adv_clamped;
    logic [16:0]       metric_sum;
    logic [4:0]        new_metric;
    logic [31:0]       new_hop;
    logic              do_wr;
    logic              drop_full;
    logic              out_free;
    logic              last_step;

    assign head      = ring[0];
    assign out_free  = !m_valid_reg || m_ready;
    assign last_step = (step_reg == IDX_W'(TABLE_DEPTH - 1));

    genvar gi;
    generate
        for (gi = 0; gi < TABLE_DEPTH; gi++) begin : g_cell
            localparam int NXT = (gi + 1) % TABLE_DEPTH;
            cell_ctrl_t cctrl;
            assign cctrl.shift = shift_en;
            assign cctrl.wr    = wr_en && (wr_idx == IDX_W'(gi));
            dvrt_cell u_cell (
                .aclk      (aclk),
                .aresetn   (aresetn),
                .ctrl      (cctrl),
                .wr_route  (wr_route),
                .nbr_route (ring[NXT]),
                .route     (ring[gi])
            );
        end
    endgenerate

    always_comb begin
        is_insert   = (in_reg.mode == MODE_LOCAL) || (in_reg.mode == MODE_ADV);
        port_ok     = ({1'b0, in_reg.port_in} < 5'(NUM_PORTS));
        adv_clamped = (|in_reg.adv_metric[31:4]) ? METRIC_INF
                                                 : {1'b0, in_reg.adv_metric[3:0]};
        metric_sum  = {12'd0, adv_clamped} + {1'b0, in_reg.link_cost};
        if (in_reg.mode == MODE_LOCAL) begin
            new_metric = METRIC_LOCAL;
            new_hop    = in_reg.dest_addr;
        end else begin
            new_metric = (metric_sum > {12'd0, METRIC_INF}) ? METRIC_INF : metric_sum[4:0];
            new_hop    = in_reg.neighbor_addr;
        end
        // an advertised route replaces a held one only on a strictly lower cost
        do_wr     = is_insert && port_ok &&
                    ((!match_found_reg && free_found_reg) ||
                     (match_found_reg && ((in_reg.mode == MODE_LOCAL) ||
                                          (match_reg.metric > new_metric))));
        drop_full = is_insert && port_ok && !match_found_reg && !free_found_reg;
        wr_idx    = match_found_reg ? match_idx_reg : free_idx_reg;
        wr_route  = '{valid: 1'b1, dest: in_reg.dest_addr, metric: new_metric,
                      next_hop: new_hop, port: in_reg.port_in};
    end

    always_comb begin
        state_next       = state_reg;
        in_next          = in_reg;
        step_next        = step_reg;
        match_found_next = match_found_reg;
        match_idx_next   = match_idx_reg;
        match_next       = match_reg;
        free_found_next  = free_found_reg;
        free_idx_next    = free_idx_reg;
        changed_next     = changed_reg;
        pend_next        = pend_reg;
        pend_valid_next  = pend_valid_reg;
        m_valid_next     = m_valid_reg && !m_ready;
        m_data_next      = m_data_reg;
        shift_en         = 1'b0;
        wr_en            = 1'b0;
        s_ready          = 1'b0;

        unique case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    in_next          = s_data;
                    step_next        = '0;
                    match_found_next = 1'b0;
                    free_found_next  = 1'b0;
                    pend_valid_next  = 1'b0;
                    unique case (s_data.mode) inside
                        MODE_LOCAL, MODE_ADV, MODE_QUERY: state_next = ST_SCAN;
                        MODE_DUMP: state_next = ST_DUMP;
                        MODE_TICK: begin
                            state_next   = changed_reg ? ST_DUMP : ST_IDLE;
                            changed_next = 1'b0;
                        end
                        default: state_next = ST_IDLE;
                    endcase
                end
            end

            ST_SCAN: begin
                // head holds original slot step_reg; lowest match and free slot win
                shift_en  = 1'b1;
                step_next = step_reg + 1'b1;
                if (head.valid && (head.dest == in_reg.dest_addr) && !match_found_reg) begin
                    match_found_next = 1'b1;
                    match_idx_next   = step_reg;
                    match_next       = head;
                end
                if (!head.valid && !free_found_reg) begin
                    free_found_next = 1'b1;
                    free_idx_next   = step_reg;
                end
                if (last_step) begin
                    step_next  = '0;
                    state_next = ST_COMMIT;
                end
            end

            ST_COMMIT: begin
                if (out_free) begin
                    wr_en        = do_wr;
                    m_valid_next = 1'b1;
                    m_data_next.addr_out   = in_reg.dest_addr;
                    m_data_next.found      = match_found_reg;
                    m_data_next.installed  = do_wr;
                    m_data_next.table_full = drop_full;
                    m_data_next.last       = 1'b1;
                    if (do_wr) begin
                        m_data_next.metric_out   = new_metric;
                        m_data_next.next_hop_out = new_hop;
                        m_data_next.port_out     = in_reg.port_in;
                    end else if (match_found_reg) begin
                        m_data_next.metric_out   = match_reg.metric;
                        m_data_next.next_hop_out = match_reg.next_hop;
                        m_data_next.port_out     = match_reg.port;
                    end else begin
                        m_data_next.metric_out   = METRIC_INF;
                        m_data_next.next_hop_out = '0;
                        m_data_next.port_out     = '0;
                    end
                    if (do_wr && (in_reg.mode == MODE_ADV)) begin
                        changed_next = 1'b1;
                    end
                    state_next = ST_IDLE;
                end
            end

            ST_DUMP: begin
                // one valid slot is held back so the final one can carry last
                if (!(head.valid && pend_valid_reg && !out_free)) begin
                    shift_en  = 1'b1;
                    step_next = step_reg + 1'b1;
                    if (head.valid) begin
                        if (pend_valid_reg) begin
                            m_valid_next = 1'b1;
                            m_data_next  = '{addr_out: pend_reg.dest,
                                             metric_out: pend_reg.metric,
                                             next_hop_out: pend_reg.next_hop,
                                             port_out: pend_reg.port,
                                             found: 1'b1, installed: 1'b0,
                                             table_full: 1'b0, last: 1'b0};
                        end
                        pend_next       = head;
                        pend_valid_next = 1'b1;
                    end
                    if (last_step) begin
                        step_next  = '0;
                        state_next = ST_FLUSH;
                    end
                end
            end

            ST_FLUSH: begin
                if (!pend_valid_reg) begin
                    state_next = ST_IDLE;
                end else if (out_free) begin
                    m_valid_next    = 1'b1;
                    m_data_next     = '{addr_out: pend_reg.dest,
                                        metric_out: pend_reg.metric,
                                        next_hop_out: pend_reg.next_hop,
                                        port_out: pend_reg.port,
                                        found: 1'b1, installed: 1'b0,
                                        table_full: 1'b0, last: 1'b1};
                    pend_valid_next = 1'b0;
                    state_next      = ST_IDLE;
                end
            end

            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            changed_reg    <= 1'b0;
            pend_valid_reg <= 1'b0;
            m_valid_reg    <= 1'b0;
        end else begin
            state_reg      <= state_next;
            changed_reg    <= changed_next;
            pend_valid_reg <= pend_valid_next;
            m_valid_reg    <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        in_reg          <= in_next;
        step_reg        <= step_next;
        match_found_reg <= match_found_next;
        match_idx_reg   <= match_idx_next;
        match_reg       <= match_next;
        free_found_reg  <= free_found_next;
        free_idx_reg    <= free_idx_next;
        pend_reg        <= pend_next;
        m_data_reg      <= m_data_next;
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

// ----- design/dvrt_checker.sv -----
// Port-level checks for the route table, bound to the top level.
module dvrt_checker
    import dvrt_pkg::*;
(
    input logic      aclk,
    input logic      aresetn,
    input logic      m_valid,
    input logic      m_ready,
    input out_item_t m_data
);

    // a waiting result item holds until taken
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result item changed while stalled");

    a_reset_idle: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");

    a_metric_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_data.metric_out <= METRIC_INF))
        else $error("metric above unreachable");

    a_full_excl: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> !(m_data.installed && m_data.table_full))
        else $error("installed and table_full both set");

    // a dropped insert never reports a held route
    a_full_unreach: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.table_full |-> !m_data.found && (m_data.metric_out == METRIC_INF))
        else $error("table_full with a route reported");

endmodule

bind distance_vector_route_table dvrt_checker u_dvrt_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);

// ----- bench/tb_distance_vector_route_table.sv -----
// Self-checking bench for the distance-vector route table: route predictor, drivers, checks.
import dvrt_pkg::*;

class route_table_scoreboard #(int DEPTH = 32, int PORTS = 16);
    route_t    slots [DEPTH];
    bit        changed;
    out_item_t expected_reports [$];
    int        errors;

    function new();
        foreach (slots[i]) slots[i] = '0;
        changed = 1'b0;
        errors  = 0;
    endfunction

    function void note_report(out_item_t r);
        expected_reports.insert(expected_reports.size(), r);
    endfunction

    // lowest valid slot holding addr, -1 on miss
    function int find_slot(logic [31:0] addr);
        for (int i = 0; i < DEPTH; i++)
            if (slots[i].valid && slots[i].dest == addr)
                return i;
        return -1;
    endfunction

    function void report_route(logic [31:0] addr, bit found, bit inst, bit full);
        out_item_t r;
        int        s;
        s = find_slot(addr);
        r.addr_out = addr;
        if (s >= 0) begin
            r.metric_out   = slots[s].metric;
            r.next_hop_out = slots[s].next_hop;
            r.port_out     = slots[s].port;
        end else begin
            r.metric_out   = METRIC_INF;
            r.next_hop_out = '0;
            r.port_out     = '0;
        end
        r.found      = found;
        r.installed  = inst;
        r.table_full = full;
        r.last       = 1'b1;
        note_report(r);
    endfunction

    function void dump_routes();
        out_item_t r;
        int        n;
        n = 0;
        for (int i = 0; i < DEPTH; i++) begin
            if (slots[i].valid) begin
                r = '{addr_out: slots[i].dest, metric_out: slots[i].metric,
                      next_hop_out: slots[i].next_hop, port_out: slots[i].port,
                      found: 1'b1, installed: 1'b0, table_full: 1'b0, last: 1'b0};
                note_report(r);
                n++;
            end
        end
        if (n > 0)
            expected_reports[expected_reports.size() - 1].last = 1'b1;
    endfunction

    // updates the table copy and queues the reports one accepted item causes
    function void apply_item(in_item_t it);
        int          hit;
        int          slot;
        bit          full;
        logic [4:0]  metric;
        logic [4:0]  clamped;
        logic [31:0] hop;
        int unsigned sum;
        case (it.mode)
            MODE_LOCAL, MODE_ADV: begin
                hit  = find_slot(it.dest_addr);
                slot = hit;
                full = 1'b0;
                if (it.mode == MODE_LOCAL) begin
                    metric = METRIC_LOCAL;
                    hop    = it.dest_addr;
                end else begin
                    clamped = (it.adv_metric > METRIC_ADV_MAX) ? METRIC_INF
                                                               : it.adv_metric[4:0];
                    sum     = clamped + it.link_cost;
                    metric  = (sum > METRIC_INF) ? METRIC_INF : sum[4:0];
                    hop     = it.neighbor_addr;
                end
                if (it.port_in < PORTS) begin
                    if (slot < 0) begin
                        for (int i = DEPTH - 1; i >= 0; i--)
                            if (!slots[i].valid)
                                slot = i;
                        full = (slot < 0);
                    end else if (it.mode == MODE_ADV && !(slots[slot].metric > metric)) begin
                        slot = -1;
                    end
                    if (slot >= 0) begin
                        slots[slot] = '{valid: 1'b1, dest: it.dest_addr, metric: metric,
                                        next_hop: hop, port: it.port_in};
                        if (it.mode == MODE_ADV)
                            changed = 1'b1;
                    end
                end else begin
                    slot = -1;
                end
                report_route(it.dest_addr, hit >= 0, slot >= 0, full);
            end
            MODE_QUERY: report_route(it.dest_addr, find_slot(it.dest_addr) >= 0, 1'b0, 1'b0);
            MODE_DUMP:  dump_routes();
            MODE_TICK: begin
                if (changed)
                    dump_routes();
                changed = 1'b0;
            end
            default: ;
        endcase
    endfunction

    function void check_report(out_item_t got);
        out_item_t want;
        if (expected_reports.size() == 0) begin
            errors++;
            $display("%0t: unexpected route report, expected none, actual addr=%h metric=%0d last=%b",
                     $time, got.addr_out, got.metric_out, got.last);
            return;
        end
        want = expected_reports.pop_front();
        if (got !== want) begin
            errors++;
            $display("%0t: route report mismatch", $time);
            $display("  expected addr=%h metric=%0d hop=%h port=%0d",
                     want.addr_out, want.metric_out, want.next_hop_out, want.port_out);
            $display("           found=%b inst=%b full=%b last=%b",
                     want.found, want.installed, want.table_full, want.last);
            $display("  actual   addr=%h metric=%0d hop=%h port=%0d",
                     got.addr_out, got.metric_out, got.next_hop_out, got.port_out);
            $display("           found=%b inst=%b full=%b last=%b",
                     got.found, got.installed, got.table_full, got.last);
        end
    endfunction
endclass

module tb_distance_vector_route_table;
    localparam int TABLE_DEPTH  = 32;
    localparam int NUM_PORTS    = 16;
    localparam int ADDR_POOL    = 36;   // a few more addresses than slots, so the table fills
    localparam int RANDOM_ITEMS = 470;
    localparam int CYCLE_LIMIT  = 1_500_000;

    localparam logic [2:0] MODE_UNUSED_LO  = 3'd5;
    localparam logic [2:0] MODE_UNUSED_MID = 3'd6;
    localparam logic [2:0] MODE_UNUSED_HI  = 3'd7;

    logic      aclk;
    logic      aresetn;
    logic      s_valid;
    logic      s_ready;
    in_item_t  s_data;
    logic      m_valid;
    logic      m_ready;
    out_item_t m_data;

    route_table_scoreboard #(TABLE_DEPTH, NUM_PORTS) board;
    logic [31:0] addr_pool [ADDR_POOL];
    bit          send_quiet;
    bit          sink_quiet;
    int          cycle_count;

    distance_vector_route_table #(
        .TABLE_DEPTH(TABLE_DEPTH),
        .NUM_PORTS  (NUM_PORTS)
    ) u_dut (
        .aclk   (aclk),
        .aresetn(aresetn),
        .s_valid(s_valid),
        .s_ready(s_ready),
        .s_data (s_data),
        .m_valid(m_valid),
        .m_ready(m_ready),
        .m_data (m_data)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    function automatic int draw_gap(bit quiet);
        return quiet ? 0 : $urandom_range(0, 19);
    endfunction

    function automatic in_item_t make_item(logic [2:0] mode, logic [31:0] dest,
                                           logic [31:0] adv, logic [15:0] cost,
                                           logic [31:0] nbr, logic [3:0] port);
        in_item_t it;
        it.mode          = mode;
        it.dest_addr     = dest;
        it.adv_metric    = adv;
        it.link_cost     = cost;
        it.neighbor_addr = nbr;
        it.port_in       = port;
        return it;
    endfunction

    // mostly small metrics and costs so updates often win; now and then the full range
    function automatic in_item_t random_item();
        in_item_t it;
        int       pick;
        pick = $urandom_range(0, 99);
        if (pick < 15)       it.mode = MODE_LOCAL;
        else if (pick < 55)  it.mode = MODE_ADV;
        else if (pick < 75)  it.mode = MODE_QUERY;
        else if (pick < 82)  it.mode = MODE_DUMP;
        else if (pick < 93)  it.mode = MODE_TICK;
        else                 it.mode = 3'($urandom_range(MODE_UNUSED_LO, MODE_UNUSED_HI));
        if (it.mode == MODE_QUERY && $urandom_range(0, 3) == 0)
            it.dest_addr = $urandom;
        else
            it.dest_addr = addr_pool[$urandom_range(0, ADDR_POOL - 1)];
        it.adv_metric = ($urandom_range(0, 99) < 85) ? $urandom_range(0, 17) : $urandom;
        pick = $urandom_range(0, 9);
        if (pick < 7)       it.link_cost = 16'($urandom_range(0, 3));
        else if (pick < 9)  it.link_cost = 16'($urandom_range(0, 16));
        else                it.link_cost = 16'($urandom_range(0, 65535));
        it.neighbor_addr = $urandom;
        it.port_in       = 4'($urandom_range(0, 15));
        return it;
    endfunction

    // valid stays up into the next item when its gap is zero
    task automatic send_item(input in_item_t it);
        int gap;
        gap = draw_gap(send_quiet);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= it;
        do @(posedge aclk); while (!s_ready);
        board.apply_item(it);
    endtask

    task automatic drain_reports();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (board.expected_reports.size() != 0) @(posedge aclk);
    endtask

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready)
            board.check_report(m_data);
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("distance_vector_route_table regression: fail");
            $finish;
        end
    end

    initial begin : result_sink
        int stall;
        int served;
        m_ready = 1'b0;
        served  = 0;
        @(posedge aclk);
        while (!aresetn) @(posedge aclk);
        forever begin
            if (served % 50 == 0)
                sink_quiet = ($urandom_range(0, 3) == 0);
            stall = draw_gap(sink_quiet);
            if (stall > 0) begin
                m_ready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (!m_valid);
            served++;
        end
    end

    initial begin : stimulus
        logic [31:0] a_addr;
        logic [31:0] b_addr;
        logic [31:0] c_addr;
        logic [31:0] d_addr;
        board       = new();
        cycle_count = 0;
        send_quiet  = 1'b0;
        sink_quiet  = 1'b0;
        s_valid     = 1'b0;
        s_data      = '0;
        aresetn     = 1'b0;
        addr_pool[0] = 32'h0000_0000;
        addr_pool[1] = 32'hFFFF_FFFF;
        for (int i = 2; i < ADDR_POOL; i++)
            addr_pool[i] = $urandom;
        a_addr = addr_pool[2];
        b_addr = addr_pool[3];
        c_addr = addr_pool[4];
        d_addr = addr_pool[5];
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;

        // empty table: no dump output, tick with flag clear, spare modes ignored
        send_item(make_item(MODE_DUMP,  $urandom, $urandom, 16'hFFFF, $urandom, 4'd15));
        send_item(make_item(MODE_TICK,  $urandom, $urandom, 16'h0000, $urandom, 4'd0));
        send_item(make_item(MODE_UNUSED_LO, $urandom, $urandom, 16'($urandom), $urandom,
                            4'($urandom)));
        send_item(make_item(MODE_UNUSED_MID, $urandom, $urandom, 16'($urandom), $urandom,
                            4'($urandom)));
        send_item(make_item(MODE_UNUSED_HI, $urandom, $urandom, 16'($urandom), $urandom,
                            4'($urandom)));
        send_item(make_item(MODE_QUERY, 32'h0000_0000, 32'd0, 16'd0, 32'd0, 4'd0));
        // local installs at address extremes
        send_item(make_item(MODE_LOCAL, 32'hFFFF_FFFF, $urandom, 16'($urandom), $urandom, 4'd15));
        send_item(make_item(MODE_LOCAL, 32'h0000_0000, $urandom, 16'($urandom), $urandom, 4'd0));
        // advertised: new, equal cost kept, clamp, saturation, strictly lower wins
        send_item(make_item(MODE_ADV, a_addr, 32'd0, 16'd0, 32'hFFFF_FFFF, 4'd3));
        send_item(make_item(MODE_ADV, a_addr, 32'd0, 16'd0, 32'h0000_0000, 4'd4));
        send_item(make_item(MODE_ADV, b_addr, 32'd15, 16'd0, $urandom, 4'd7));
        send_item(make_item(MODE_ADV, b_addr, 32'd16, 16'd0, $urandom, 4'd8));
        send_item(make_item(MODE_ADV, c_addr, 32'hFFFF_FFFF, 16'd0, $urandom, 4'd9));
        send_item(make_item(MODE_ADV, c_addr, 32'd3, 16'hFFFF, $urandom, 4'd10));
        send_item(make_item(MODE_ADV, c_addr, 32'd2, 16'd5, $urandom, 4'd11));
        send_item(make_item(MODE_ADV, 32'hFFFF_FFFF, 32'd1, 16'd1, $urandom, 4'd12));
        // local overwrite of an advertised route
        send_item(make_item(MODE_LOCAL, c_addr, $urandom, 16'($urandom), $urandom, 4'd1));
        send_item(make_item(MODE_QUERY, c_addr, 32'd0, 16'd0, 32'd0, 4'd0));
        send_item(make_item(MODE_QUERY, 32'hFFFF_FFFF, 32'd0, 16'd0, 32'd0, 4'd0));
        // tick with flag set dumps, the next one is silent
        send_item(make_item(MODE_TICK, $urandom, $urandom, 16'($urandom), $urandom, 4'($urandom)));
        send_item(make_item(MODE_TICK, $urandom, $urandom, 16'($urandom), $urandom, 4'($urandom)));
        send_item(make_item(MODE_DUMP, $urandom, $urandom, 16'($urandom), $urandom, 4'($urandom)));
        send_item(make_item(MODE_ADV, d_addr, 32'd14, 16'd1, $urandom, 4'd2));
        send_item(make_item(MODE_TICK, $urandom, $urandom, 16'($urandom), $urandom, 4'($urandom)));

        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            if (n % 40 == 0)
                send_quiet = ($urandom_range(0, 3) == 0);
            if (n == RANDOM_ITEMS / 2)
                drain_reports();
            send_item(random_item());
        end

        drain_reports();
        repeat (TABLE_DEPTH + 8) @(posedge aclk);
        if (board.errors == 0 && board.expected_reports.size() == 0)
            $display("distance_vector_route_table regression: pass");
        else
            $display("distance_vector_route_table regression: fail");
        $finish;
    end
endmodule

// ----- filelist.f -----
design/dvrt_pkg.sv
design/dvrt_cell.sv
design/distance_vector_route_table.sv
design/dvrt_checker.sv
bench/tb_distance_vector_route_table.sv
